// ===== design/rbp_pkg.sv =====
// Shared constants and types for the replicate border padder.
package rbp_pkg;

    // Image geometry limits
    localparam int DIM_W = 13;
    localparam int CNT_W = 12;
    localparam int PAD_W = 3;
    localparam int ADDR_W = 25;
    localparam int VAL_W = 32;
    localparam int SPAN_W = 4;
    localparam int BEAT_CNT_W = 6;

    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;
    localparam logic [PAD_W-1:0] MAX_PAD = 3'd7;
    localparam logic [BEAT_CNT_W-1:0] LAST_BEAT_IDX = 6'd63;

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SIDE_PAD = 2'd2;
    localparam logic [1:0] REG_TOP_BOTTOM_PAD = 2'd3;

    // Reset values of the configuration registers
    localparam logic [DIM_W-1:0] RST_WIDTH = 13'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd480;
    localparam logic [PAD_W-1:0] RST_SIDE_PAD = 3'd1;
    localparam logic [PAD_W-1:0] RST_TB_PAD = 3'd1;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // One classified pixel: the rectangle of padded cells it fills
    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [ADDR_W-1:0] row_base;   // first padded row times padded width
        logic [DIM_W-1:0]  col0;       // first padded column
        logic [SPAN_W-1:0] nrows_m1;   // rows in span minus one
        logic [SPAN_W-1:0] ncols_m1;   // columns in span minus one
    } desc_t;

    // Queue status seen by both neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== design/replicate_border_pad_top.sv =====
// Replicate border padder: pixels in, padded-image write beats out.
// An accepted pixel passes the stage register, the queue, the span walker and the
// output register. A pixel emits n write beats (n is capped at 64), one beat per
// cycle while the output register is free, then the walker loads the next pixel.
// Reset: config registers return to 640 x 480 with one pixel of padding,
// raster counters clear to row 0 column 0, queue and output stage empty.
module replicate_border_pad_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [rbp_pkg::DIM_W-1:0]   cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [rbp_pkg::VAL_W-1:0]   pixel_value,
    output logic                        empty,
    input  logic                        pop,
    output logic [rbp_pkg::ADDR_W-1:0]  write_address,
    output logic [rbp_pkg::VAL_W-1:0]   write_value,
    output logic                        last_write
);
    import rbp_pkg::*;

    desc_t            q_din, q_dout;
    q_stat_t          q_stat;
    logic             q_push, q_pop;
    logic [DIM_W-1:0] pad_width;

    // Classify pixels
    rbp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .pixel_value (pixel_value),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_din       (q_din),
        .pad_width   (pad_width)
    );

    // Decouple front and back
    rbp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (q_push),
        .din   (q_din),
        .rd_en (q_pop),
        .dout  (q_dout),
        .stat  (q_stat)
    );

    // Emit write beats
    rbp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .q_dout        (q_dout),
        .q_pop         (q_pop),
        .pad_width     (pad_width),
        .empty         (empty),
        .pop           (pop),
        .write_address (write_address),
        .write_value   (write_value),
        .last_write    (last_write)
    );

endmodule

// ===== design/rbp_front.sv =====
// Front end: config registers, raster counters and span classification.
module rbp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [rbp_pkg::DIM_W-1:0]   cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [rbp_pkg::VAL_W-1:0]   pixel_value,
    input  rbp_pkg::q_stat_t            q_stat,
    output logic                        q_push,
    output rbp_pkg::desc_t              q_din,
    output logic [rbp_pkg::DIM_W-1:0]   pad_width
);
    import rbp_pkg::*;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [PAD_W-1:0] side_reg, tb_reg;
    logic [CNT_W-1:0] row_reg, col_reg, row_next, col_next;

    logic [DIM_W-1:0] w_eff, h_eff, r_cur, c_cur;
    logic [PAD_W-1:0] sp_eff, tp_eff;
    logic [DIM_W-1:0] r0, r1, c0, c1, r_inc, c_inc, nrows, ncols;
    logic             accept, stg_ready;

    logic                  stg_valid_reg;
    logic [VAL_W-1:0]      stg_value_reg;
    logic [DIM_W-1:0]      stg_r0_reg, stg_c0_reg;
    logic [SPAN_W-1:0]     stg_nrows_reg, stg_ncols_reg;
    logic [2*DIM_W-1:0]    row_prod;

    // Clamp the geometry
    always_comb
    begin
        if (width_reg == '0)
            w_eff = 13'd1;
        else if (width_reg > MAX_DIM)
            w_eff = MAX_DIM;
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = 13'd1;
        else if (height_reg > MAX_DIM)
            h_eff = MAX_DIM;
        else
            h_eff = height_reg;
        sp_eff = (side_reg > MAX_PAD) ? MAX_PAD : side_reg;
        tp_eff = (tb_reg > MAX_PAD) ? MAX_PAD : tb_reg;
    end

    assign pad_width = w_eff + {9'd0, sp_eff, 1'b0};

    // Span of padded rows and columns for the current pixel
    always_comb
    begin
        r_cur = ({1'b0, row_reg} >= h_eff) ? '0 : {1'b0, row_reg};
        c_cur = ({1'b0, col_reg} >= w_eff) ? '0 : {1'b0, col_reg};
        r0 = (r_cur == '0) ? '0 : r_cur + {10'd0, tp_eff};
        r1 = (r_cur == h_eff - 13'd1) ? h_eff + {9'd0, tp_eff, 1'b0} - 13'd1
                                      : r_cur + {10'd0, tp_eff};
        c0 = (c_cur == '0) ? '0 : c_cur + {10'd0, sp_eff};
        c1 = (c_cur == w_eff - 13'd1) ? w_eff + {9'd0, sp_eff, 1'b0} - 13'd1
                                      : c_cur + {10'd0, sp_eff};
        nrows = r1 - r0;
        ncols = c1 - c0;
        r_inc = r_cur + 13'd1;
        c_inc = c_cur + 13'd1;
        if (c_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (r_inc >= h_eff) ? '0 : r_inc[CNT_W-1:0];
        end
        else
        begin
            col_next = c_inc[CNT_W-1:0];
            row_next = r_cur[CNT_W-1:0];
        end
    end

    // Input handshake: stage register drains into the queue
    assign stg_ready = !stg_valid_reg || !q_stat.full;
    assign full = !stg_ready;
    assign accept = push && stg_ready;

    // Config registers and raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            side_reg <= RST_SIDE_PAD;
            tb_reg <= RST_TB_PAD;
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:    width_reg <= cfg_data;
                REG_IMAGE_HEIGHT:   height_reg <= cfg_data;
                REG_SIDE_PAD:       side_reg <= cfg_data[PAD_W-1:0];
                REG_TOP_BOTTOM_PAD: tb_reg <= cfg_data[PAD_W-1:0];
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (stg_ready)
            stg_valid_reg <= push;
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_value_reg <= pixel_value;
            stg_r0_reg <= r0;
            stg_c0_reg <= c0;
            stg_nrows_reg <= nrows[SPAN_W-1:0];
            stg_ncols_reg <= ncols[SPAN_W-1:0];
        end
    end

    // Row base address into the queue
    assign row_prod = stg_r0_reg * pad_width;
    assign q_push = stg_valid_reg && !q_stat.full;

    always_comb
    begin
        q_din.value = stg_value_reg;
        q_din.row_base = row_prod[ADDR_W-1:0];
        q_din.col0 = stg_c0_reg;
        q_din.nrows_m1 = stg_nrows_reg;
        q_din.ncols_m1 = stg_ncols_reg;
    end

`ifndef NO_ASSERTIONS
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_reg} < w_eff)
        else $error("column counter outside image width");
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, row_reg} < h_eff)
        else $error("row counter outside image height");
`endif

endmodule

// ===== design/rbp_queue.sv =====
// Short descriptor queue between front and back.
module rbp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  rbp_pkg::desc_t   din,
    input  logic             rd_en,
    output rbp_pkg::desc_t   dout,
    output rbp_pkg::q_stat_t stat
);
    import rbp_pkg::*;

    desc_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign stat.full = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign dout = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= din;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !stat.full)
        else $error("write into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !stat.empty)
        else $error("read from empty queue");
`endif

endmodule

// ===== design/rbp_back.sv =====
// Back end: walks each pixel's span and emits write beats.
module rbp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rbp_pkg::q_stat_t            q_stat,
    input  rbp_pkg::desc_t              q_dout,
    output logic                        q_pop,
    input  logic [rbp_pkg::DIM_W-1:0]   pad_width,
    output logic                        empty,
    input  logic                        pop,
    output logic [rbp_pkg::ADDR_W-1:0]  write_address,
    output logic [rbp_pkg::VAL_W-1:0]   write_value,
    output logic                        last_write
);
    import rbp_pkg::*;

    logic                  active_reg;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [VAL_W-1:0]      value_reg;
    logic [DIM_W-1:0]      row_skip_reg;
    logic [SPAN_W-1:0]     ncols_reg, col_left_reg, row_left_reg;
    logic [BEAT_CNT_W-1:0] beat_reg;

    logic                  out_valid_reg, out_last_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [VAL_W-1:0]      out_value_reg;

    logic out_free, emit, last_beat;

    assign out_free = !out_valid_reg || pop;
    assign emit = active_reg && out_free;
    assign q_pop = !active_reg && !q_stat.empty;
    assign last_beat = (col_left_reg == '0 && row_left_reg == '0) ||
                       (beat_reg == LAST_BEAT_IDX);

    // Next address: step a column, or jump to the span start of the next row
    assign addr_next = (col_left_reg == '0)
                       ? addr_reg + {12'd0, row_skip_reg}
                       : addr_reg + 25'd1;

    // Span walker control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 1'b0;
        else if (q_pop)
            active_reg <= 1'b1;
        else if (emit && last_beat)
            active_reg <= 1'b0;
    end

    // Span walker datapath
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            addr_reg <= q_dout.row_base + {12'd0, q_dout.col0};
            value_reg <= q_dout.value;
            row_skip_reg <= pad_width - {9'd0, q_dout.ncols_m1};
            ncols_reg <= q_dout.ncols_m1;
            col_left_reg <= q_dout.ncols_m1;
            row_left_reg <= q_dout.nrows_m1;
            beat_reg <= '0;
        end
        else if (emit)
        begin
            addr_reg <= addr_next;
            beat_reg <= beat_reg + 1'b1;
            if (col_left_reg == '0)
            begin
                col_left_reg <= ncols_reg;
                row_left_reg <= row_left_reg - 1'b1;
            end
            else
            begin
                col_left_reg <= col_left_reg - 1'b1;
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= emit;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_addr_reg <= addr_reg;
            out_value_reg <= value_reg;
            out_last_reg <= last_beat;
        end
    end

    assign empty = !out_valid_reg;
    assign write_address = out_addr_reg;
    assign write_value = out_value_reg;
    assign last_write = out_last_reg;

`ifndef NO_ASSERTIONS
    a_load_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(active_reg) |-> $past(!q_stat.empty))
        else $error("walker started without a queued pixel");
    a_beat_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && beat_reg == LAST_BEAT_IDX) |=> (out_last_reg && !active_reg))
        else $error("beat cap not honored");
`endif

endmodule
